@@ rtl/core/ipbrl_pkg.sv @@
// Shared types and codes for the IP block and rate limit filter.
package ipbrl_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CountW  = 33;
  localparam int unsigned StatusW = 4;
  localparam int unsigned OpW     = 3;

  typedef enum logic [OpW-1:0] {
    OP_PACKET    = 3'd0,
    OP_BLOCK_ADD = 3'd1,
    OP_BLOCK_REM = 3'd2,
    OP_RATE_ADD  = 3'd3,
    OP_RATE_REM  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPT       = 4'd0,
    ST_DROP_BLOCKED = 4'd1,
    ST_DROP_RATE    = 4'd2,
    ST_ADDED        = 4'd3,
    ST_UPDATED      = 4'd4,
    ST_REMOVED      = 4'd5,
    ST_PRESENT      = 4'd6,
    ST_NOT_FOUND    = 4'd7,
    ST_FULL         = 4'd8
  } status_e;

  // Raw input beat.
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  packet_length;
    logic [AddrW-1:0] rate_bytes;
    logic [TickW-1:0] now_tick;
  } item_t;

endpackage

@@ rtl/core/ip_block_and_rate_limit_filter_unit.sv @@
// Top level of the IP block and rate limit filter.
//
// Input channel: push/full queue; a beat carries operation, address,
// packet_length, rate_bytes and now_tick. Result channel: empty/pop queue
// carrying status_o, one result per input beat, in order.
// Configuration: cfg_valid/cfg_ready write of window_ticks (always ready);
// write only while idle.
// A two-beat input queue feeds the execute engine. Each item passes
// through the parallel address match step and then the table update
// and status compute step; the engine takes no new item until the
// last one has left its update step.
// The status sits in an output register; a stalled receiver holds it and
// the engine holds the next item in its update step, the input queue
// fills and full rises. Reset empties all tables and queues and sets
// window_ticks to 1000.
module ip_block_and_rate_limit_filter_unit #(
  parameter int unsigned BLOCK_ENTRIES = 16,
  parameter int unsigned RATE_ENTRIES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] rate_bytes_i,
  input  logic [31:0] now_tick_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] window_ticks_q;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) window_ticks_q <= 32'd1000;
    else if (cfg_valid) window_ticks_q <= cfg_data_i;
  end

  ipbrl_pkg::item_t in_item, q_item;
  logic q_valid, q_take, res_valid;

  assign in_item.operation     = operation_i;
  assign in_item.address       = address_i;
  assign in_item.packet_length = packet_length_i;
  assign in_item.rate_bytes    = rate_bytes_i;
  assign in_item.now_tick      = now_tick_i;

  ipbrl_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .item_i(in_item), .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  ipbrl_back #(.BlockEntries(BLOCK_ENTRIES), .RateEntries(RATE_ENTRIES)) u_back (
    .clk_i, .rst_ni, .window_ticks_i(window_ticks_q),
    .valid_i(q_valid), .take_o(q_take), .item_i(q_item),
    .res_valid_o(res_valid), .res_ready_i(pop), .status_o
  );

  assign empty = !res_valid;

endmodule

@@ rtl/core/ipbrl_front.sv @@
// Front end: input skid queue of two beats feeding the execute stage.
module ipbrl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ipbrl_pkg::item_t   item_i,
  output logic               valid_o,
  input  logic               take_i,
  output ipbrl_pkg::item_t   item_o
);

  ipbrl_pkg::item_t mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push && !full) wp_q <= ~wp_q;
      if (take_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, take_i && valid_o};
    end
  end

endmodule

@@ rtl/core/ipbrl_back.sv @@
// Back end: table match step, then the state update and status step.
module ipbrl_back #(
  parameter int unsigned BlockEntries = 16,
  parameter int unsigned RateEntries  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ipbrl_pkg::TickW-1:0]   window_ticks_i,
  input  logic                          valid_i,
  output logic                          take_o,
  input  ipbrl_pkg::item_t              item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [ipbrl_pkg::StatusW-1:0] status_o
);

  localparam int unsigned BIdxW = (BlockEntries > 1) ? $clog2(BlockEntries) : 1;
  localparam int unsigned RIdxW = (RateEntries > 1) ? $clog2(RateEntries) : 1;

  typedef enum logic [1:0] {
    S_MATCH = 2'b01,
    S_EXEC  = 2'b10
  } state_e;

  state_e state_q;

  logic [ipbrl_pkg::AddrW-1:0]  baddr_q [BlockEntries];
  logic [BlockEntries-1:0]      bvalid_q;
  logic [ipbrl_pkg::AddrW-1:0]  raddr_q [RateEntries];
  logic [ipbrl_pkg::AddrW-1:0]  rlim_q  [RateEntries];
  logic [ipbrl_pkg::TickW-1:0]  rstart_q[RateEntries];
  logic [ipbrl_pkg::CountW-1:0] rcnt_q  [RateEntries];
  logic [RateEntries-1:0]       rvalid_q;

  // Match results registered between the two steps.
  ipbrl_pkg::item_t it_q;
  logic             bhit_q, rhit_q, bfree_q, rfree_q;
  logic [BIdxW-1:0] bidx_q, bfidx_q;
  logic [RIdxW-1:0] ridx_q, rfidx_q;

  logic             bhit_d, rhit_d, bfree_d, rfree_d;
  logic [BIdxW-1:0] bidx_d, bfidx_d;
  logic [RIdxW-1:0] ridx_d, rfidx_d;

  always_comb begin
    bhit_d = 1'b0; bidx_d = '0; bfree_d = 1'b0; bfidx_d = '0;
    for (int i = BlockEntries - 1; i >= 0; i--) begin
      if (bvalid_q[i] && baddr_q[i] == item_i.address) begin
        bhit_d = 1'b1; bidx_d = BIdxW'(i);
      end
      if (!bvalid_q[i]) begin
        bfree_d = 1'b1; bfidx_d = BIdxW'(i);
      end
    end
    rhit_d = 1'b0; ridx_d = '0; rfree_d = 1'b0; rfidx_d = '0;
    for (int i = RateEntries - 1; i >= 0; i--) begin
      if (rvalid_q[i] && raddr_q[i] == item_i.address) begin
        rhit_d = 1'b1; ridx_d = RIdxW'(i);
      end
      if (!rvalid_q[i]) begin
        rfree_d = 1'b1; rfidx_d = RIdxW'(i);
      end
    end
  end

  logic out_busy_q;
  logic exec;
  assign take_o = (state_q == S_MATCH) && valid_i;
  assign exec   = (state_q == S_EXEC) && (!out_busy_q || res_ready_i);

  // Packet path arithmetic on the matched rate entry.
  logic [ipbrl_pkg::TickW-1:0]  diff;
  logic                         restart;
  logic [ipbrl_pkg::CountW-1:0] base_cnt;
  logic [ipbrl_pkg::CountW:0]   sum;
  logic [ipbrl_pkg::CountW-1:0] new_cnt;
  always_comb begin
    diff     = rstart_q[ridx_q] + window_ticks_i - it_q.now_tick;
    restart  = diff[ipbrl_pkg::TickW-1];
    base_cnt = restart ? '0 : rcnt_q[ridx_q];
    sum      = {1'b0, base_cnt} + (ipbrl_pkg::CountW + 1)'(it_q.packet_length);
    new_cnt  = sum[ipbrl_pkg::CountW] ? '1 : sum[ipbrl_pkg::CountW-1:0];
  end

  ipbrl_pkg::status_e st;
  always_comb begin
    case (it_q.operation)
      ipbrl_pkg::OP_PACKET:
        st = bhit_q ? ipbrl_pkg::ST_DROP_BLOCKED :
             !rhit_q ? ipbrl_pkg::ST_ACCEPT :
             (new_cnt > {1'b0, rlim_q[ridx_q]}) ? ipbrl_pkg::ST_DROP_RATE :
             ipbrl_pkg::ST_ACCEPT;
      ipbrl_pkg::OP_BLOCK_ADD:
        st = bhit_q ? ipbrl_pkg::ST_PRESENT :
             bfree_q ? ipbrl_pkg::ST_ADDED : ipbrl_pkg::ST_FULL;
      ipbrl_pkg::OP_BLOCK_REM:
        st = bhit_q ? ipbrl_pkg::ST_REMOVED : ipbrl_pkg::ST_NOT_FOUND;
      ipbrl_pkg::OP_RATE_ADD:
        st = rhit_q ? ipbrl_pkg::ST_UPDATED :
             rfree_q ? ipbrl_pkg::ST_ADDED : ipbrl_pkg::ST_FULL;
      ipbrl_pkg::OP_RATE_REM:
        st = rhit_q ? ipbrl_pkg::ST_REMOVED : ipbrl_pkg::ST_NOT_FOUND;
      default: st = ipbrl_pkg::ST_NOT_FOUND;
    endcase
  end

  logic [RIdxW-1:0] rwi;
  assign rwi = rhit_q ? ridx_q : rfidx_q;

  // Payload tables, no reset.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      it_q <= item_i;
      bhit_q <= bhit_d; bidx_q <= bidx_d; bfree_q <= bfree_d; bfidx_q <= bfidx_d;
      rhit_q <= rhit_d; ridx_q <= ridx_d; rfree_q <= rfree_d; rfidx_q <= rfidx_d;
    end
    if (exec) begin
      status_o <= st;
      case (it_q.operation)
        ipbrl_pkg::OP_PACKET: begin
          if (!bhit_q && rhit_q) begin
            if (restart) rstart_q[ridx_q] <= it_q.now_tick;
            rcnt_q[ridx_q] <= new_cnt;
          end
        end
        ipbrl_pkg::OP_BLOCK_ADD: begin
          if (!bhit_q && bfree_q) baddr_q[bfidx_q] <= it_q.address;
        end
        ipbrl_pkg::OP_RATE_ADD: begin
          if (rhit_q || rfree_q) begin
            raddr_q[rwi]  <= it_q.address;
            rlim_q[rwi]   <= it_q.rate_bytes;
            rstart_q[rwi] <= it_q.now_tick;
            rcnt_q[rwi]   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_MATCH;
      bvalid_q   <= '0;
      rvalid_q   <= '0;
      out_busy_q <= 1'b0;
    end else begin
      if (take_o) state_q <= S_EXEC;
      if (exec) begin
        state_q    <= S_MATCH;
        out_busy_q <= 1'b1;
        case (it_q.operation)
          ipbrl_pkg::OP_BLOCK_ADD:
            if (!bhit_q && bfree_q) bvalid_q[bfidx_q] <= 1'b1;
          ipbrl_pkg::OP_BLOCK_REM:
            if (bhit_q) bvalid_q[bidx_q] <= 1'b0;
          ipbrl_pkg::OP_RATE_ADD:
            if (!rhit_q && rfree_q) rvalid_q[rfidx_q] <= 1'b1;
          ipbrl_pkg::OP_RATE_REM:
            if (rhit_q) rvalid_q[ridx_q] <= 1'b0;
          default: ;
        endcase
      end else if (res_ready_i) begin
        out_busy_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_busy_q;

endmodule

@@ verif/ipbrl_checker.sv @@
// Checker for the IP block and rate limit filter: predicts each status and compares it.
`timescale 1ns / 1ps
module ipbrl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] rate_bytes_i,
  input  logic [31:0] now_tick_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  status_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data_i,
  output int          fail_count,
  output int          pending,
  output int          status_seen
);

  localparam int NBlk = 16;
  localparam int NRate = 16;
  localparam logic [32:0] CountMax = 33'h1_FFFF_FFFF;

  logic [31:0]         window_len;
  logic [31:0]         blk_addr [NBlk];
  logic                blk_used [NBlk];
  logic [31:0]         rt_addr  [NRate];
  logic [31:0]         rt_limit [NRate];
  logic [31:0]         rt_start [NRate];
  logic [32:0]         rt_bytes [NRate];
  logic                rt_used  [NRate];
  ipbrl_pkg::status_e  status_q [$];

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int find_blk(input logic [31:0] a);
    for (int i = 0; i < NBlk; i++) if (blk_used[i] && blk_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_rt(input logic [31:0] a);
    for (int i = 0; i < NRate; i++) if (rt_used[i] && rt_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic ipbrl_pkg::status_e filter_status(input logic [2:0] op,
                                                       input logic [31:0] a,
                                                       input logic [15:0] len,
                                                       input logic [31:0] lim,
                                                       input logic [31:0] now);
    int r;
    logic [31:0] diff;
    logic [33:0] sum;
    case (op)
      ipbrl_pkg::OP_PACKET: begin
        if (find_blk(a) >= 0) return ipbrl_pkg::ST_DROP_BLOCKED;
        r = find_rt(a);
        if (r < 0) return ipbrl_pkg::ST_ACCEPT;
        diff = rt_start[r] + window_len - now;
        if (diff[31]) begin
          rt_start[r] = now;
          rt_bytes[r] = '0;
        end
        sum = {1'b0, rt_bytes[r]} + 34'(len);
        rt_bytes[r] = (sum > {1'b0, CountMax}) ? CountMax : sum[32:0];
        return (rt_bytes[r] > {1'b0, rt_limit[r]}) ? ipbrl_pkg::ST_DROP_RATE :
                                                     ipbrl_pkg::ST_ACCEPT;
      end
      ipbrl_pkg::OP_BLOCK_ADD: begin
        if (find_blk(a) >= 0) return ipbrl_pkg::ST_PRESENT;
        for (int i = 0; i < NBlk; i++) if (!blk_used[i]) begin
          blk_used[i] = 1'b1;
          blk_addr[i] = a;
          return ipbrl_pkg::ST_ADDED;
        end
        return ipbrl_pkg::ST_FULL;
      end
      ipbrl_pkg::OP_BLOCK_REM: begin
        r = find_blk(a);
        if (r < 0) return ipbrl_pkg::ST_NOT_FOUND;
        blk_used[r] = 1'b0;
        return ipbrl_pkg::ST_REMOVED;
      end
      ipbrl_pkg::OP_RATE_ADD: begin
        r = find_rt(a);
        if (r < 0) begin
          for (int i = 0; i < NRate; i++) if (!rt_used[i] && r < 0) r = i;
          if (r < 0) return ipbrl_pkg::ST_FULL;
          rt_used[r] = 1'b1;
          rt_addr[r] = a;
          filter_status = ipbrl_pkg::ST_ADDED;
        end else begin
          filter_status = ipbrl_pkg::ST_UPDATED;
        end
        rt_limit[r] = lim;
        rt_start[r] = now;
        rt_bytes[r] = '0;
        return filter_status;
      end
      ipbrl_pkg::OP_RATE_REM: begin
        r = find_rt(a);
        if (r < 0) return ipbrl_pkg::ST_NOT_FOUND;
        rt_used[r] = 1'b0;
        return ipbrl_pkg::ST_REMOVED;
      end
      default: return ipbrl_pkg::ST_NOT_FOUND;
    endcase
  endfunction

  assign pending = status_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len <= 32'd1000;
      status_q.delete();
      fail_count <= 0;
      status_seen <= 0;
      for (int i = 0; i < NBlk; i++) blk_used[i] = 1'b0;
      for (int i = 0; i < NRate; i++) rt_used[i] = 1'b0;
    end else begin
      // Check the result beat first; a new beat never lands in the same cycle's compare.
      if (pop && !empty) begin
        status_seen <= status_seen + 1;
        if (status_q.size() == 0) begin
          report($sformatf("unexpected status %0d", status_o));
        end else if (status_o !== status_q[0]) begin
          report($sformatf("status %0d, predicted %0d", status_o, status_q[0]));
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      if (push && !full)
        status_q.push_back(filter_status(operation_i, address_i, packet_length_i,
                                         rate_bytes_i, now_tick_i));
      if (cfg_valid && cfg_ready) window_len <= cfg_data_i;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the IP block and rate limit filter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  operation_i = '0;
  logic [31:0] address_i = '0;
  logic [15:0] packet_length_i = '0;
  logic [31:0] rate_bytes_i = '0;
  logic [31:0] now_tick_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  status_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending, status_seen;
  int          cycle_count = 0;
  int          send_idle_pct = 14, recv_idle_pct = 78;
  int          hold_off = 0;
  logic [31:0] tick = '0;
  logic [31:0] addr_pool [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ip_block_and_rate_limit_filter_unit dut (.*);

  ipbrl_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Push stays high after the accepting edge; the next beat replaces its data or an idle drops it.
  task automatic send_beat(input logic [2:0] op, input logic [31:0] a,
                           input logic [15:0] len, input logic [31:0] lim,
                           input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    address_i <= a;
    packet_length_i <= len;
    rate_bytes_i <= lim;
    now_tick_i <= now;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain_then_config(input logic [31:0] w);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= w;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly addresses from a small pool so rules and packets collide.
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(9) < 8) return addr_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  task automatic random_phase(input int n);
    logic [2:0] op;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      op = (k < 50) ? ipbrl_pkg::OP_PACKET : (k < 62) ? ipbrl_pkg::OP_BLOCK_ADD :
           (k < 72) ? ipbrl_pkg::OP_BLOCK_REM : (k < 86) ? ipbrl_pkg::OP_RATE_ADD :
           (k < 96) ? ipbrl_pkg::OP_RATE_REM : 3'($urandom_range(7));
      tick = tick + $urandom_range(($urandom_range(3) == 0) ? 2000 : 200);
      if ($urandom_range(49) == 0) tick = $urandom();
      send_beat(op, pick_addr(), ($urandom_range(9) == 0) ? 16'($urandom()) :
                16'($urandom_range(1500)),
                ($urandom_range(7) == 0) ? $urandom() : 32'($urandom_range(6000)), tick);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, full tables, saturation, wrap.
    send_beat(ipbrl_pkg::OP_BLOCK_ADD, 32'h0, '0, '0, '0);
    send_beat(ipbrl_pkg::OP_BLOCK_ADD, 32'h0, '0, '0, '0);
    send_beat(ipbrl_pkg::OP_RATE_ADD, 32'h0, '0, 32'h0, 32'hFFFF_FFF0);
    send_beat(ipbrl_pkg::OP_PACKET, 32'h0, 16'hFFFF, '0, 32'hFFFF_FFF0);
    send_beat(ipbrl_pkg::OP_BLOCK_REM, 32'h0, '0, '0, '0);
    send_beat(ipbrl_pkg::OP_BLOCK_REM, 32'h0, '0, '0, '0);
    send_beat(ipbrl_pkg::OP_PACKET, 32'h0, 16'h0, '0, 32'h0000_0100);
    send_beat(ipbrl_pkg::OP_PACKET, 32'h0, 16'h1, '0, 32'h0000_0500);
    send_beat(ipbrl_pkg::OP_RATE_ADD, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_beat(ipbrl_pkg::OP_RATE_ADD, 32'hFFFF_FFFF, '0, 32'h5, 32'h8000_0000);
    send_beat(ipbrl_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'h5, '0, 32'h8000_0001);
    send_beat(ipbrl_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'h1, '0, 32'h8000_0002);
    send_beat(ipbrl_pkg::OP_RATE_REM, 32'hFFFF_FFFF, '0, '0, '0);
    send_beat(ipbrl_pkg::OP_RATE_REM, 32'hFFFF_FFFF, '0, '0, '0);
    send_beat(3'd5, 32'h1234_5678, 16'h1, 32'h1, 32'h1);
    send_beat(3'd7, 32'hA5A5_5A5A, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    for (int i = 0; i < 17; i++)
      send_beat(ipbrl_pkg::OP_BLOCK_ADD, 32'h100 + 32'(i), '0, '0, '0);
    for (int i = 0; i < 17; i++)
      send_beat(ipbrl_pkg::OP_RATE_ADD, 32'h200 + 32'(i), '0, 32'd100, '0);
    for (int i = 0; i < 17; i++)
      send_beat(ipbrl_pkg::OP_BLOCK_REM, 32'h100 + 32'(i), '0, '0, '0);
    for (int i = 0; i < 16; i++)
      send_beat(ipbrl_pkg::OP_RATE_REM, 32'h200 + 32'(i), '0, '0, '0);

    // Huge limit with the max window; every packet here restarts the window.
    drain_then_config(32'hFFFF_FFFF);
    send_beat(ipbrl_pkg::OP_RATE_ADD, 32'h77, '0, 32'hFFFF_FFFF, 32'h10);
    for (int i = 0; i < 20; i++)
      send_beat(ipbrl_pkg::OP_PACKET, 32'h77, 16'hFFFF, '0, 32'h11);
    send_beat(ipbrl_pkg::OP_RATE_REM, 32'h77, '0, '0, '0);

    drain_then_config(32'd0);
    random_phase(150);
    // Long receiver stall while the sender keeps pushing.
    hold_off = 300;
    random_phase(150);

    drain_then_config(32'd1);
    send_idle_pct = 78;
    recv_idle_pct = 14;
    random_phase(200);

    drain_then_config(32'd1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(200);
    drain_then_config($urandom_range(5000, 100));
    random_phase(100);

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered directed table full/saturation/wrap cases and random rule and packet");
    $display("traffic under four window settings; %0d statuses checked.", status_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ipbrl_pkg.sv
rtl/core/ipbrl_front.sv
rtl/core/ipbrl_back.sv
rtl/core/ip_block_and_rate_limit_filter_unit.sv
verif/ipbrl_checker.sv
verif/tb_top.sv
